/* rtl/core/sbs_pkg.sv */
package sbs_pkg;

    // Default sizing of the record store and the key.
    localparam int MAX_RECORDS_DEF = 64;
    localparam int KEY_BITS_DEF    = 32;

    // The tag width is fixed by the record format.
    localparam int TAG_BITS = 6;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_SWAP_A,
        S_SWAP_B,
        S_EMIT_RD,
        S_EMIT_LD
    } sbs_state_t;

    // Controls for the shared minimum unit.
    typedef struct packed {
        logic init;   // take the returning record as the running minimum
        logic step;   // compare the returning record against the minimum
    } sbs_min_ctrl_t;

endpackage

/* rtl/core/sbs_ram.sv */
module sbs_ram
    #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 64
    )
    (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/sbs_min_unit.sv */
module sbs_min_unit
    import sbs_pkg::*;
    #(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int IDX_W    = 7
    )
    (
    input  logic                         clk,
    input  sbs_min_ctrl_t                ctrl,
    input  logic [KEY_BITS+TAG_BITS-1:0] rec,
    input  logic [IDX_W-1:0]             rec_idx,
    output logic [KEY_BITS+TAG_BITS-1:0] best_rec,
    output logic [IDX_W-1:0]             best_idx
    );

    logic [KEY_BITS+TAG_BITS-1:0] best_rec_reg;
    logic [KEY_BITS+TAG_BITS-1:0] best_rec_next;
    logic [IDX_W-1:0]             best_idx_reg;
    logic [IDX_W-1:0]             best_idx_next;
    logic                         smaller;

    // A record replaces the minimum only when its key is strictly smaller,
    // so the first of several equal minima is kept.
    assign smaller = best_rec_reg[KEY_BITS+TAG_BITS-1:TAG_BITS] >
                     rec[KEY_BITS+TAG_BITS-1:TAG_BITS];

    always_comb
    begin
        best_rec_next = best_rec_reg;
        best_idx_next = best_idx_reg;
        if (ctrl.init || (ctrl.step && smaller))
        begin
            best_rec_next = rec;
            best_idx_next = rec_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        best_rec_reg <= best_rec_next;
        best_idx_reg <= best_idx_next;
    end

    assign best_rec = best_rec_reg;
    assign best_idx = best_idx_reg;

endmodule

/* rtl/core/selection_sort_by_key.sv */
// Records are taken one a cycle while item_stall is low, until the word flagged
// last closes the set. Sorting uses one comparator that walks the store one
// record a cycle through the single read port of the record RAM.
// Each sorted record is read, then loaded into a free output register.
// Reset clears the sequencer and the record count; the RAM needs no clearing
// pass because only entries written in the current set are ever read.
module selection_sort_by_key
    import sbs_pkg::*;
    #(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
    )
    (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [KEY_BITS-1:0] key,
    input  logic [TAG_BITS-1:0] tag,
    input  logic                last,
    output logic                res_valid,
    input  logic                res_stall,
    output logic [KEY_BITS-1:0] sorted_key,
    output logic [TAG_BITS-1:0] sorted_tag,
    output logic                final_res
    );

    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int ADDR_W = $clog2(MAX_RECORDS);
    localparam int REC_W  = KEY_BITS + TAG_BITS;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_RECORDS);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);

    sbs_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              rv_reg, rv_next;
    logic [CNT_W-1:0]  ridx_reg, ridx_next;
    logic [CNT_W-1:0]  em_reg, em_next;
    logic [REC_W-1:0]  pos_rec_reg, pos_rec_next;
    logic              out_valid_reg, out_valid_next;
    logic [REC_W-1:0]  out_rec_reg, out_rec_next;
    logic              out_final_reg, out_final_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [REC_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [REC_W-1:0]  ram_rdata;

    sbs_min_ctrl_t     min_ctrl;
    logic [REC_W-1:0]  best_rec;
    logic [CNT_W-1:0]  best_idx;

    logic              item_take;
    logic              out_free;
    logic [CNT_W-1:0]  set_size;

    sbs_ram
        #(
        .WIDTH (REC_W),
        .DEPTH (MAX_RECORDS)
        )
    u_ram
        (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
        );

    sbs_min_unit
        #(
        .KEY_BITS (KEY_BITS),
        .IDX_W    (CNT_W)
        )
    u_min
        (
        .clk      (clk),
        .ctrl     (min_ctrl),
        .rec      (ram_rdata),
        .rec_idx  (ridx_reg),
        .best_rec (best_rec),
        .best_idx (best_idx)
        );

    assign item_stall = (state_reg != S_LOAD);
    assign item_take  = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !res_stall;
    assign set_size   = (count_reg < FULL) ? count_reg + ONE : count_reg;

    // Sequencer: load, scan for the minimum, swap, and emit.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        pos_next       = pos_reg;
        iss_next       = iss_reg;
        rv_next        = 1'b0;
        ridx_next      = ridx_reg;
        em_next        = em_reg;
        pos_rec_next   = pos_rec_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_rec_next   = out_rec_reg;
        out_final_next = out_final_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[ADDR_W-1:0];
        ram_wdata      = {key, tag};
        ram_raddr      = iss_reg[ADDR_W-1:0];
        min_ctrl       = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (item_take)
                begin
                    // A word arriving into a full store is dropped.
                    ram_we     = (count_reg < FULL);
                    count_next = set_size;
                    if (last)
                    begin
                        count_next = '0;
                        n_next     = set_size;
                        pos_next   = '0;
                        iss_next   = '0;
                        em_next    = '0;
                        if (set_size < TWO)
                        begin
                            state_next = S_EMIT_RD;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                // Issue one read a cycle; the data comes back through the registered read port.
                if (iss_reg < n_reg)
                begin
                    ram_raddr = iss_reg[ADDR_W-1:0];
                    rv_next   = 1'b1;
                    ridx_next = iss_reg;
                    iss_next  = iss_reg + ONE;
                end
                if (rv_reg)
                begin
                    if (ridx_reg == pos_reg)
                    begin
                        min_ctrl.init = 1'b1;
                        pos_rec_next  = ram_rdata;
                    end
                    else
                    begin
                        min_ctrl.step = 1'b1;
                    end
                    if (ridx_reg == n_reg - ONE)
                    begin
                        rv_next    = 1'b0;
                        state_next = S_SWAP_A;
                    end
                end
            end

            S_SWAP_A:
            begin
                // The minimum moves into the current position.
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[ADDR_W-1:0];
                ram_wdata  = best_rec;
                state_next = S_SWAP_B;
            end

            S_SWAP_B:
            begin
                // The record that stood there takes the minimum's old place.
                ram_we    = 1'b1;
                ram_waddr = best_idx[ADDR_W-1:0];
                ram_wdata = pos_rec_reg;
                pos_next  = pos_reg + ONE;
                iss_next  = pos_reg + ONE;
                if (pos_reg + TWO < n_reg)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end

            S_EMIT_RD:
            begin
                // Read the next record once the output register can take it.
                ram_raddr = em_reg[ADDR_W-1:0];
                if (out_free)
                begin
                    state_next = S_EMIT_LD;
                end
            end

            S_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_rec_next   = ram_rdata;
                out_final_next = (em_reg + ONE == n_reg);
                em_next        = em_reg + ONE;
                if (em_reg + ONE == n_reg)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_EMIT_RD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Indices and payload registers.
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        pos_reg       <= pos_next;
        iss_reg       <= iss_next;
        ridx_reg      <= ridx_next;
        em_reg        <= em_next;
        pos_rec_reg   <= pos_rec_next;
        out_rec_reg   <= out_rec_next;
        out_final_reg <= out_final_next;
    end

    assign res_valid  = out_valid_reg;
    assign sorted_key = out_rec_reg[REC_W-1:TAG_BITS];
    assign sorted_tag = out_rec_reg[TAG_BITS-1:0];
    assign final_res  = out_final_reg;

endmodule
